@@ rtl/rsp_pkg.sv @@
// Shared constants, types and GF(2^8) helpers for the Reed-Solomon parity encoder.
// No dependencies; used by rsp_genpoly and reed_solomon_parity_encoder.
package rsp_pkg;

    localparam int MAX_PARITY = 32;
    localparam int CNT_W = $clog2(MAX_PARITY + 1);
    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam logic [CNT_W-1:0] RESET_PARITY = CNT_W'(10);
    localparam int CFG_W = 6;

    typedef logic [MAX_PARITY-1:0][7:0] byte_vec_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        x = {1'b0, a};
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                acc = acc ^ x[7:0];
            end
            x = {x[7:0], 1'b0};
            if (x[8]) begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ GF_POLY[7:0]) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > MAX_PARITY) begin
            r = CNT_W'(MAX_PARITY);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

@@ rtl/rsp_genpoly.sv @@
// Generator polynomial builder: multiplies in one root (x - alpha^i) per cycle.
// Depends on rsp_pkg.
module rsp_genpoly (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rsp_pkg::CNT_W-1:0] count,
    output rsp_pkg::byte_vec_t        coeffs,
    output logic                      busy
);

    rsp_pkg::byte_vec_t          coef_reg, coef_next;
    logic [7:0]                  root_reg, root_next;
    logic [rsp_pkg::CNT_W-1:0]   iter_reg, iter_next;

    always_comb begin
        coef_next = coef_reg;
        root_next = root_reg;
        iter_next = iter_reg;
        if (start) begin
            coef_next = '0;
            root_next = 8'h01;
            iter_next = count;
        end else if (iter_reg != '0) begin
            coef_next[0] = coef_reg[0] ^ root_reg;
            for (int k = 1; k < rsp_pkg::MAX_PARITY; k++) begin
                coef_next[k] = coef_reg[k] ^ rsp_pkg::gf_mul(coef_reg[k-1], root_reg);
            end
            root_next = rsp_pkg::gf_xtime(root_reg);
            iter_next = iter_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
            root_reg <= 8'h01;
            iter_reg <= rsp_pkg::clamp_count(rsp_pkg::CFG_W'(rsp_pkg::RESET_PARITY));
        end else begin
            coef_reg <= coef_next;
            root_reg <= root_next;
            iter_reg <= iter_next;
        end
    end

    assign coeffs = coef_reg;
    assign busy   = (iter_reg != '0);

endmodule

@@ rtl/reed_solomon_parity_encoder.sv @@
// Top level of the systematic Reed-Solomon parity encoder over GF(2^8), polynomial 0x11D.
// Depends on rsp_pkg and rsp_genpoly.
//
//   Channel   Direction  Handshake          Content
//   s_        in         s_tvalid/s_tready  data_byte in tdata, last_byte in tlast
//   m_        out        m_tvalid/m_tready  parity_byte in tdata, parity_last in tlast
//   cfg_      in         cfg_we             parity_count in cfg_wdata
//
// One data beat is taken every cycle that s_tready is high; the whole LFSR update is
// one registered step. A last beat copies the remainder into a parity buffer that
// drains one beat a cycle while m_tready is high, so a block gives parity_count output
// beats; a last beat waits while that buffer is busy. After reset and after every
// configuration write the generator is rebuilt one root per cycle; s_tready stays low.
module reed_solomon_parity_encoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rsp_pkg::CFG_W-1:0]     cfg_wdata,    // parity_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,      // [7:0] data_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,      // [7:0] parity_byte
    output logic                          m_tlast
);

    rsp_pkg::byte_vec_t         gen;
    logic                       gen_busy;
    logic [rsp_pkg::CNT_W-1:0]  n_reg, n_next;
    rsp_pkg::byte_vec_t         rem_reg, rem_next, rem_upd;
    rsp_pkg::byte_vec_t         par_reg, par_next;
    logic [rsp_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]                 fb;
    logic                       par_free, s_fire, m_fire;

    rsp_genpoly u_genpoly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_we),
        .count   (rsp_pkg::clamp_count(cfg_wdata)),
        .coeffs  (gen),
        .busy    (gen_busy)
    );

    assign m_fire   = m_tvalid && m_tready;
    assign par_free = (cnt_reg == '0) || ((cnt_reg == rsp_pkg::CNT_W'(1)) && m_tready);
    assign s_tready = !gen_busy && (!s_tlast || par_free);
    assign s_fire   = s_tvalid && s_tready;

    assign fb = s_tdata ^ rem_reg[0];

    always_comb begin
        for (int j = 0; j < rsp_pkg::MAX_PARITY; j++) begin
            if ((j + 1 < rsp_pkg::MAX_PARITY) && (rsp_pkg::CNT_W'(j + 1) < n_reg)) begin
                rem_upd[j] = rem_reg[(j + 1) % rsp_pkg::MAX_PARITY]
                             ^ rsp_pkg::gf_mul(fb, gen[j]);
            end else begin
                rem_upd[j] = rsp_pkg::gf_mul(fb, gen[j]);
            end
        end
    end

    always_comb begin
        n_next   = n_reg;
        rem_next = rem_reg;
        par_next = par_reg;
        cnt_next = cnt_reg;
        if (m_fire) begin
            for (int j = 0; j < rsp_pkg::MAX_PARITY - 1; j++) begin
                par_next[j] = par_reg[j + 1];
            end
            par_next[rsp_pkg::MAX_PARITY-1] = 8'h00;
            cnt_next = cnt_reg - 1'b1;
        end
        if (cfg_we) begin
            n_next   = rsp_pkg::clamp_count(cfg_wdata);
            rem_next = '0;
        end else if (s_fire) begin
            if (s_tlast) begin
                rem_next = '0;
                par_next = rem_upd;
                cnt_next = n_reg;
            end else begin
                rem_next = rem_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg   <= rsp_pkg::clamp_count(rsp_pkg::CFG_W'(rsp_pkg::RESET_PARITY));
            rem_reg <= '0;
            cnt_reg <= '0;
        end else begin
            n_reg   <= n_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        par_reg <= par_next;
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = par_reg[0];
    assign m_tlast  = (cnt_reg == rsp_pkg::CNT_W'(1));

    a_no_accept_while_building: assert property (
        @(posedge aclk) disable iff (!aresetn) gen_busy |-> !s_tready)
        else $error("input beat accepted while the generator is being built");

    a_last_starts_parity: assert property (
        @(posedge aclk) disable iff (!aresetn) (s_fire && s_tlast && !cfg_we) |=> m_tvalid)
        else $error("no parity beat after a last data beat");

    a_cfg_starts_build: assert property (
        @(posedge aclk) disable iff (!aresetn) cfg_we |=> gen_busy)
        else $error("configuration write did not start a generator build");

    a_count_bounded: assert property (
        @(posedge aclk) disable iff (!aresetn) cnt_reg <= n_reg)
        else $error("parity beat count exceeds the parity count");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for reed_solomon_parity_encoder: a directed table and then random blocks
// under several idling patterns, all checked beat by beat against a parity predictor.
// Depends on rsp_pkg and the encoder RTL only.
module tb_top;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 19;
    localparam int NO_WRITE = -1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [7:0] pbyte;
        logic       plast;
    } parity_beat_t;

    typedef struct {
        int         cfg;
        logic [7:0] data;
        bit         last;
        bit         typed;
        logic [7:0] typed_val;
    } stim_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [rsp_pkg::CFG_W-1:0] cfg_wdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [7:0]                s_tdata;
    logic                      s_tlast;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [7:0]                m_tdata;
    logic                      m_tlast;

    logic [7:0]   gen_tap [rsp_pkg::MAX_PARITY];
    logic [7:0]   lfsr_rem [rsp_pkg::MAX_PARITY];
    int           active_parity;
    parity_beat_t parity_q [$];
    int           mismatch_count;
    int           quiet_cycles;
    int           send_gap;
    int           stall_pct;

    // An all-zero message gives all-zero parity, and with one parity byte the generator is
    // x + 1, so the parity is the XOR of the block's bytes.
    stim_row_t plan [22] = '{
        '{NO_WRITE, 8'h00, 1'b1, 1'b1, 8'h00},
        '{NO_WRITE, 8'hFF, 1'b1, 1'b0, 8'h00},
        '{NO_WRITE, 8'h80, 1'b0, 1'b0, 8'h00},
        '{NO_WRITE, 8'h01, 1'b0, 1'b0, 8'h00},
        '{NO_WRITE, 8'h55, 1'b1, 1'b0, 8'h00},
        '{1,        8'hA5, 1'b0, 1'b0, 8'h00},
        '{NO_WRITE, 8'h5A, 1'b1, 1'b1, 8'hFF},
        '{NO_WRITE, 8'hFF, 1'b1, 1'b1, 8'hFF},
        '{NO_WRITE, 8'h00, 1'b1, 1'b1, 8'h00},
        '{32,       8'h12, 1'b0, 1'b0, 8'h00},
        '{NO_WRITE, 8'hFF, 1'b0, 1'b0, 8'h00},
        '{NO_WRITE, 8'h00, 1'b1, 1'b0, 8'h00},
        '{NO_WRITE, 8'h00, 1'b1, 1'b1, 8'h00},
        '{0,        8'h3C, 1'b0, 1'b0, 8'h00},
        '{NO_WRITE, 8'hC3, 1'b1, 1'b1, 8'hFF},
        '{63,       8'hAA, 1'b1, 1'b0, 8'h00},
        '{33,       8'h77, 1'b0, 1'b0, 8'h00},
        '{NO_WRITE, 8'h01, 1'b0, 1'b0, 8'h00},
        '{5,        8'h00, 1'b1, 1'b1, 8'h00},
        '{NO_WRITE, 8'h01, 1'b1, 1'b0, 8'h00},
        '{NO_WRITE, 8'h80, 1'b1, 1'b0, 8'h00},
        '{NO_WRITE, 8'hFE, 1'b1, 1'b0, 8'h00}
    };

    reed_solomon_parity_encoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shift-and-add product in GF(2^8), most significant multiplier bit first.
    function automatic logic [7:0] gf256_product(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 7; k >= 0; k--) begin
            p = {p[6:0], 1'b0} ^ (p[7] ? rsp_pkg::GF_POLY[7:0] : 8'h00);
            if (b[k]) begin
                p = p ^ a;
            end
        end
        return p;
    endfunction

    function automatic void load_generator(logic [rsp_pkg::CFG_W-1:0] raw);
        logic [7:0] poly [rsp_pkg::MAX_PARITY+1];
        logic [7:0] root;
        if (raw == '0) begin
            active_parity = 1;
        end else if (int'(raw) > rsp_pkg::MAX_PARITY) begin
            active_parity = rsp_pkg::MAX_PARITY;
        end else begin
            active_parity = int'(raw);
        end
        foreach (poly[i]) poly[i] = 8'h00;
        poly[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < active_parity; i++) begin
            poly[i+1] = gf256_product(poly[i], root);
            for (int j = i; j > 0; j--) begin
                poly[j] = poly[j] ^ gf256_product(poly[j-1], root);
            end
            root = gf256_product(root, 8'h02);
        end
        for (int i = 0; i < rsp_pkg::MAX_PARITY; i++) begin
            gen_tap[i] = (i < active_parity) ? poly[i+1] : 8'h00;
            lfsr_rem[i] = 8'h00;
        end
    endfunction

    // Clocks one message byte into the remainder; on the last byte the parity is queued.
    function automatic void absorb_byte(logic [7:0] b, logic last, bit typed, logic [7:0] tv);
        logic [7:0] fb;
        parity_beat_t pb;
        fb = b ^ lfsr_rem[0];
        for (int j = 0; j + 1 < active_parity; j++) begin
            lfsr_rem[j] = lfsr_rem[j+1];
        end
        lfsr_rem[active_parity-1] = 8'h00;
        for (int j = 0; j < active_parity; j++) begin
            lfsr_rem[j] = lfsr_rem[j] ^ gf256_product(fb, gen_tap[j]);
        end
        if (last) begin
            for (int j = 0; j < active_parity; j++) begin
                pb.pbyte = typed ? tv : lfsr_rem[j];
                pb.plast = (j == active_parity - 1);
                parity_q.push_back(pb);
                lfsr_rem[j] = 8'h00;
            end
        end
    endfunction

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin
                send_gap = 0;
                stall_pct = 0;
            end
            IDLE_SENDER: begin
                send_gap = 47;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                send_gap = 0;
                stall_pct = 47;
            end
            default: begin
                send_gap = 36;
                stall_pct = 36;
            end
        endcase
    endtask

    task automatic send_beat(logic [7:0] d, logic last, bit typed, logic [7:0] tv);
        while (send_gap != 0 && $urandom_range(0, 99) < send_gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        absorb_byte(d, last, typed, tv);
        @(negedge aclk);
    endtask

    task automatic write_parity_count(logic [rsp_pkg::CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        while (parity_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        load_generator(v);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        parity_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (parity_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected parity beat %02h last %0b", m_tdata, m_tlast);
                end
            end else begin
                want = parity_q.pop_front();
                if (m_tdata !== want.pbyte || m_tlast !== want.plast) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("parity mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.pbyte, want.plast, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [rsp_pkg::CFG_W-1:0] cfg_v;
        logic [7:0]                d;
        int                        blk_len;
        int                        in_blk;
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        set_idle(IDLE_NONE);
        load_generator(rsp_pkg::CFG_W'(rsp_pkg::RESET_PARITY));
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].cfg != NO_WRITE) begin
                write_parity_count(rsp_pkg::CFG_W'(plan[r].cfg));
            end
            send_beat(plan[r].data, plan[r].last, plan[r].typed, plan[r].typed_val);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: cfg_v = rsp_pkg::CFG_W'(32);
                1: cfg_v = rsp_pkg::CFG_W'(1);
                4: cfg_v = '1;
                6: cfg_v = '0;
                default: cfg_v = rsp_pkg::CFG_W'($urandom_range(0, 63));
            endcase
            write_parity_count(cfg_v);
            set_idle(idle_mode_t'(p % 4));
            blk_len = 0;
            in_blk = 0;
            // A phase may stop part-way through a block; the next write then discards it.
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (in_blk == 0) begin
                    blk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                          : $urandom_range(1, 6);
                end
                if ($urandom_range(0, 9) == 0) begin
                    d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end else begin
                    d = 8'($urandom_range(0, 255));
                end
                in_blk++;
                send_beat(d, in_blk >= blk_len, 1'b0, 8'h00);
                if (in_blk >= blk_len) begin
                    in_blk = 0;
                end
            end
        end

        s_tvalid <= 1'b0;
        set_idle(IDLE_NONE);
        while (parity_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && parity_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
